### hdl/fcr_pkg.sv
// package with shared types and constants of the framed command responder
`timescale 1ns / 1ps

package fcr_pkg;

    localparam logic [7:0] FRAME_HEAD = 8'hAA;
    localparam logic [7:0] FRAME_TAIL = 8'h55;
    localparam logic [7:0] ACK_FLAG   = 8'h80;

    localparam logic [7:0] CMD_ACK_A      = 8'h20;
    localparam logic [7:0] CMD_ACK_B      = 8'h21;
    localparam logic [7:0] CMD_ACK_C      = 8'h22;
    localparam logic [7:0] CMD_GET_DEV    = 8'h36;
    localparam logic [7:0] CMD_SET_DEV    = 8'h37;
    localparam logic [7:0] CMD_GET_PROD   = 8'h38;
    localparam logic [7:0] CMD_SET_PROD   = 8'h39;
    localparam logic [7:0] RSP_GET_DEV    = 8'hB6;
    localparam logic [7:0] RSP_GET_PROD   = 8'hB8;

    localparam logic [7:0] MIN_LENGTH     = 8'd3;
    localparam logic [8:0] POS_MAX        = 9'd511;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef enum logic [2:0] {
        OP_ACK,
        OP_DEV,
        OP_PROD,
        OP_STORE_DEV,
        OP_STORE_PROD
    } fcr_op_t;

    typedef struct packed {
        fcr_op_t    op;
        logic [7:0] ctrl;
    } fcr_item_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fcr_q_status_t;

endpackage

### hdl/framed_command_responder_top.sv
// top level of the framed command responder
//
//  channel   dir  tdata            tlast      tuser
//  s_axis    in   [7:0] rx_byte    rx_last    -
//  m_axis    out  [7:0] tx_byte    tx_last    -
//
// one received word per cycle; the frame verdict is taken on the last word
// a reply's head word is loaded as its command pops, then its words leave at one per cycle
// while the receiver is ready, set by the back sequencer; up to two decoded commands wait in the queue
// input stalls while the queue is full, and after an id store command until
// all earlier replies are out and the store copy is done
// reset clears position, header fields, id stores, queue and sequencer
`timescale 1ns / 1ps

module framed_command_responder_top
    import fcr_pkg::*;
#(
    parameter int DEVICE_ID_BYTES  = 14,
    parameter int PRODUCT_ID_BYTES = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] tx_byte
    output logic       m_axis_tlast
);

    localparam int STAGE_DEPTH = (DEVICE_ID_BYTES > PRODUCT_ID_BYTES)
                                 ? DEVICE_ID_BYTES : PRODUCT_ID_BYTES;

    fcr_q_status_t               q_status;
    fcr_item_t                   push_item;
    fcr_item_t                   pop_item;
    logic                        push;
    logic                        pop;
    logic                        hold;
    logic                        back_idle;
    logic [STAGE_DEPTH-1:0][7:0] staging;

    fcr_front #(
        .DEV_BYTES   (DEVICE_ID_BYTES),
        .PROD_BYTES  (PRODUCT_ID_BYTES),
        .STAGE_DEPTH (STAGE_DEPTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_status      (q_status),
        .back_idle     (back_idle),
        .push          (push),
        .push_item     (push_item),
        .hold          (hold),
        .staging       (staging)
    );

    fcr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .status    (q_status)
    );

    fcr_back #(
        .DEV_BYTES   (DEVICE_ID_BYTES),
        .PROD_BYTES  (PRODUCT_ID_BYTES),
        .STAGE_DEPTH (STAGE_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_status      (q_status),
        .q_item        (pop_item),
        .pop           (pop),
        .staging       (staging),
        .idle          (back_idle),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    assert property (@(posedge clk) disable iff (!rst_n) !(push && q_status.full))
        else $error("push into full queue");

    assert property (@(posedge clk) disable iff (!rst_n) !(pop && q_status.empty))
        else $error("pop from empty queue");

    assert property (@(posedge clk) disable iff (!rst_n) hold |-> !s_axis_tready)
        else $error("input taken while store pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata == FRAME_TAIL))
        else $error("reply end word is not the frame tail");

endmodule

### hdl/fcr_queue.sv
// two-entry queue of decoded commands between front and back
`timescale 1ns / 1ps

module fcr_queue
    import fcr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  fcr_item_t     push_item,
    input  logic          pop,
    output fcr_item_t     pop_item,
    output fcr_q_status_t status
);

    fcr_item_t            entries_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign pop_item     = entries_reg[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == Q_CNT_W'(Q_DEPTH));

endmodule

### hdl/fcr_front.sv
// receive side: frame parsing, payload staging and command decode
`timescale 1ns / 1ps

module fcr_front
    import fcr_pkg::*;
#(
    parameter int DEV_BYTES   = 14,
    parameter int PROD_BYTES  = 8,
    parameter int STAGE_DEPTH = 14
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,
    input  logic                        s_axis_tlast,
    input  fcr_q_status_t               q_status,
    input  logic                        back_idle,
    output logic                        push,
    output fcr_item_t                   push_item,
    output logic                        hold,
    output logic [STAGE_DEPTH-1:0][7:0] staging
);

    logic [8:0]                  pos_reg;
    logic [7:0]                  head_reg;
    logic [7:0]                  len_reg;
    logic [7:0]                  cmd_reg;
    logic [7:0]                  tail_reg;
    logic [STAGE_DEPTH-1:0][7:0] staging_reg;
    logic                        hold_reg;

    logic       accept;
    logic [7:0] head_next;
    logic [7:0] len_next;
    logic [7:0] cmd_next;
    logic [7:0] tail_next;
    logic [8:0] tail_pos;
    logic [8:0] offset;
    logic       frame_ok;
    logic       has_op;
    logic       is_store;

    assign s_axis_tready = !hold_reg && !q_status.full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        head_next = (pos_reg == 9'd0) ? s_axis_tdata : head_reg;
        len_next  = (pos_reg == 9'd1) ? s_axis_tdata : len_reg;
        cmd_next  = (pos_reg == 9'd2) ? s_axis_tdata : cmd_reg;
        tail_pos  = {1'b0, len_next} + 9'd1;
        tail_next = (pos_reg >= 9'd2 && pos_reg == tail_pos) ? s_axis_tdata : tail_reg;
        offset    = pos_reg - 9'd3;
        frame_ok  = (head_next == FRAME_HEAD) && (len_next >= MIN_LENGTH)
                    && (pos_reg >= tail_pos) && (tail_next == FRAME_TAIL);
    end

    always_comb
    begin
        has_op         = 1'b0;
        is_store       = 1'b0;
        push_item.op   = OP_ACK;
        push_item.ctrl = cmd_next | ACK_FLAG;
        case (cmd_next)
            CMD_ACK_A, CMD_ACK_B, CMD_ACK_C:
            begin
                has_op = 1'b1;
            end
            CMD_GET_DEV:
            begin
                has_op         = 1'b1;
                push_item.op   = OP_DEV;
                push_item.ctrl = RSP_GET_DEV;
            end
            CMD_GET_PROD:
            begin
                has_op         = 1'b1;
                push_item.op   = OP_PROD;
                push_item.ctrl = RSP_GET_PROD;
            end
            CMD_SET_DEV:
            begin
                has_op       = (len_next == 8'(DEV_BYTES + 3));
                is_store     = has_op;
                push_item.op = OP_STORE_DEV;
            end
            CMD_SET_PROD:
            begin
                has_op       = (len_next == 8'(PROD_BYTES + 3));
                is_store     = has_op;
                push_item.op = OP_STORE_PROD;
            end
            default:
            begin
                has_op = 1'b0;
            end
        endcase
    end

    assign push = accept && s_axis_tlast && frame_ok && has_op;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < STAGE_DEPTH; i++)
            begin
                if (pos_reg >= 9'd3 && offset == 9'(i))
                begin
                    staging_reg[i] <= s_axis_tdata;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            head_reg <= '0;
            len_reg  <= '0;
            cmd_reg  <= '0;
            tail_reg <= '0;
            hold_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                head_reg <= head_next;
                len_reg  <= len_next;
                cmd_reg  <= cmd_next;
                tail_reg <= tail_next;
                if (s_axis_tlast)
                begin
                    pos_reg <= '0;
                end
                else if (pos_reg != POS_MAX)
                begin
                    pos_reg <= pos_reg + 9'd1;
                end
            end
            // store waits for all earlier replies and the copy itself
            if (push && is_store)
            begin
                hold_reg <= 1'b1;
            end
            else if (hold_reg && q_status.empty && back_idle)
            begin
                hold_reg <= 1'b0;
            end
        end
    end

    assign hold    = hold_reg;
    assign staging = staging_reg;

endmodule

### hdl/fcr_back.sv
// transmit side: id stores and reply frame sequencer
`timescale 1ns / 1ps

module fcr_back
    import fcr_pkg::*;
#(
    parameter int DEV_BYTES   = 14,
    parameter int PROD_BYTES  = 8,
    parameter int STAGE_DEPTH = 14
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  fcr_q_status_t               q_status,
    input  fcr_item_t                   q_item,
    output logic                        pop,
    input  logic [STAGE_DEPTH-1:0][7:0] staging,
    output logic                        idle,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [7:0]                  m_axis_tdata,
    output logic                        m_axis_tlast
);

    localparam int MAXP = (DEV_BYTES > PROD_BYTES) ? DEV_BYTES : PROD_BYTES;
    localparam int CW   = $clog2(MAXP + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEN,
        S_CTRL,
        S_PAY,
        S_SUM,
        S_TAIL
    } state_t;

    state_t                    state_reg;
    fcr_op_t                   op_reg;
    logic [7:0]                ctrl_reg;
    logic [CW-1:0]             plen_reg;
    logic [CW-1:0]             idx_reg;
    logic [7:0]                sum_reg;
    logic [7:0]                tdata_reg;
    logic                      tlast_reg;
    logic                      tvalid_reg;
    logic [DEV_BYTES-1:0][7:0]  dev_store_reg;
    logic [PROD_BYTES-1:0][7:0] prod_store_reg;

    logic          can_load;
    logic          is_reply;
    logic          load_word;
    logic [CW-1:0] item_plen;
    logic [7:0]    pay_byte;
    logic [7:0]    len_byte;

    assign can_load = !tvalid_reg || m_axis_tready;
    assign is_reply = (q_item.op == OP_ACK) || (q_item.op == OP_DEV) || (q_item.op == OP_PROD);
    assign pop      = (state_reg == S_IDLE) && !q_status.empty && (!is_reply || can_load);
    assign len_byte = 8'(plen_reg) + 8'd3;

    // a new output word is loaded this cycle
    assign load_word = (state_reg == S_IDLE) ? (pop && is_reply) : can_load;

    always_comb
    begin
        case (q_item.op)
            OP_DEV:  item_plen = CW'(DEV_BYTES);
            OP_PROD: item_plen = CW'(PROD_BYTES);
            default: item_plen = CW'(1);
        endcase
    end

    always_comb
    begin
        pay_byte = 8'h00;
        case (op_reg)
            OP_DEV:
            begin
                for (int i = 0; i < DEV_BYTES; i++)
                begin
                    if (idx_reg == CW'(i))
                    begin
                        pay_byte = dev_store_reg[i];
                    end
                end
            end
            OP_PROD:
            begin
                for (int i = 0; i < PROD_BYTES; i++)
                begin
                    if (idx_reg == CW'(i))
                    begin
                        pay_byte = prod_store_reg[i];
                    end
                end
            end
            default:
            begin
                pay_byte = 8'h00;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_store_reg  <= '0;
            prod_store_reg <= '0;
        end
        else if (pop)
        begin
            if (q_item.op == OP_STORE_DEV)
            begin
                for (int i = 0; i < DEV_BYTES; i++)
                begin
                    dev_store_reg[i] <= staging[i];
                end
            end
            if (q_item.op == OP_STORE_PROD)
            begin
                for (int i = 0; i < PROD_BYTES; i++)
                begin
                    prod_store_reg[i] <= staging[i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            op_reg     <= OP_ACK;
            ctrl_reg   <= '0;
            plen_reg   <= '0;
            idx_reg    <= '0;
            sum_reg    <= '0;
            tdata_reg  <= '0;
            tlast_reg  <= 1'b0;
            tvalid_reg <= 1'b0;
        end
        else
        begin
            if (load_word)
            begin
                tvalid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (pop && is_reply)
                    begin
                        op_reg     <= q_item.op;
                        ctrl_reg   <= q_item.ctrl;
                        plen_reg   <= item_plen;
                        tdata_reg  <= FRAME_HEAD;
                        tlast_reg  <= 1'b0;
                        state_reg  <= S_LEN;
                    end
                end
                S_LEN:
                begin
                    if (can_load)
                    begin
                        tdata_reg  <= len_byte;
                        sum_reg    <= len_byte;
                        state_reg  <= S_CTRL;
                    end
                end
                S_CTRL:
                begin
                    if (can_load)
                    begin
                        tdata_reg  <= ctrl_reg;
                        sum_reg    <= sum_reg + ctrl_reg;
                        idx_reg    <= '0;
                        state_reg  <= S_PAY;
                    end
                end
                S_PAY:
                begin
                    if (can_load)
                    begin
                        tdata_reg  <= pay_byte;
                        sum_reg    <= sum_reg + pay_byte;
                        idx_reg    <= idx_reg + CW'(1);
                        if (idx_reg == plen_reg - CW'(1))
                        begin
                            state_reg <= S_SUM;
                        end
                    end
                end
                S_SUM:
                begin
                    if (can_load)
                    begin
                        tdata_reg  <= sum_reg;
                        state_reg  <= S_TAIL;
                    end
                end
                S_TAIL:
                begin
                    if (can_load)
                    begin
                        tdata_reg  <= FRAME_TAIL;
                        tlast_reg  <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign idle          = (state_reg == S_IDLE);
    assign m_axis_tvalid = tvalid_reg;
    assign m_axis_tdata  = tdata_reg;
    assign m_axis_tlast  = tlast_reg;

endmodule

### tb/testbench.sv
// testbench for the framed command responder: byte frames in, predicted reply words checked out
`timescale 1ns / 1ps

module testbench;
    import fcr_pkg::*;

    localparam int DEVICE_ID_BYTES  = 14;
    localparam int PRODUCT_ID_BYTES = 8;
    localparam int STAGE_DEPTH      = 14;
    localparam int ITEM_WORDS       = 230;

    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         hold;
    } rx_word_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } tx_word_t;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;
    logic       s_axis_tlast  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;

    rx_word_t   rx_words[$];
    tx_word_t   tx_words_due[$];
    logic [7:0] frame_bytes[$];
    logic [7:0] frame_body[$];
    logic [7:0] reply_body[$];

    // predictor state
    logic [8:0] rx_pos;
    logic [7:0] rx_head;
    logic [7:0] rx_length;
    logic [7:0] rx_command;
    logic [7:0] rx_tail;
    logic [7:0] rx_stage[STAGE_DEPTH];
    logic [7:0] dev_id[DEVICE_ID_BYTES];
    logic [7:0] prod_id[PRODUCT_ID_BYTES];

    int         mismatches   = 0;
    int         queued_words = 0;
    int         send_gap     = 0;
    bit         send_calm    = 1'b0;
    int         take_stall   = 0;
    int         stall_draw   = 0;
    bit         take_calm    = 1'b0;
    rx_word_t   next_word;

    framed_command_responder_top uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        if (mismatches < 40)
            $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic due_word(input logic [7:0] data, input logic last);
        tx_word_t w;
        w.data = data;
        w.last = last;
        tx_words_due.push_back(w);
    endtask

    task automatic push_reply(input logic [7:0] ctrl);
        logic [7:0] len;
        logic [7:0] sum;
        len = 8'(reply_body.size() + 3);
        sum = len + ctrl;
        due_word(FRAME_HEAD, 1'b0);
        due_word(len, 1'b0);
        due_word(ctrl, 1'b0);
        foreach (reply_body[i])
        begin
            due_word(reply_body[i], 1'b0);
            sum = sum + reply_body[i];
        end
        due_word(sum, 1'b0);
        due_word(FRAME_TAIL, 1'b1);
        reply_body.delete();
    endtask

    task automatic judge_frame(input int count);
        if (rx_head != FRAME_HEAD || rx_length < MIN_LENGTH)
            return;
        if (count < int'(rx_length) + 2 || rx_tail != FRAME_TAIL)
            return;
        case (rx_command)
            CMD_ACK_A, CMD_ACK_B, CMD_ACK_C:
            begin
                reply_body.push_back(8'h00);
                push_reply(rx_command | ACK_FLAG);
            end
            CMD_GET_DEV:
            begin
                foreach (dev_id[i])
                    reply_body.push_back(dev_id[i]);
                push_reply(RSP_GET_DEV);
            end
            CMD_GET_PROD:
            begin
                foreach (prod_id[i])
                    reply_body.push_back(prod_id[i]);
                push_reply(RSP_GET_PROD);
            end
            CMD_SET_DEV:
                if (int'(rx_length) - 3 == DEVICE_ID_BYTES)
                    foreach (dev_id[i])
                        dev_id[i] = rx_stage[i];
            CMD_SET_PROD:
                if (int'(rx_length) - 3 == PRODUCT_ID_BYTES)
                    foreach (prod_id[i])
                        prod_id[i] = rx_stage[i];
            default:
                ;
        endcase
    endtask

    task automatic absorb_rx_word(input logic [7:0] b, input logic last);
        int p;
        p = rx_pos;
        if (p == 0)
            rx_head = b;
        else if (p == 1)
            rx_length = b;
        else if (p == 2)
            rx_command = b;
        if (p >= 3 && p - 3 < STAGE_DEPTH)
            rx_stage[p - 3] = b;
        if (p >= 2 && p == int'(rx_length) + 1)
            rx_tail = b;
        if (last)
        begin
            judge_frame(p + 1);
            rx_pos = '0;
        end
        else if (rx_pos != POS_MAX)
            rx_pos = rx_pos + 9'd1;
    endtask

    task automatic check_tx_word(input logic [7:0] data, input logic last);
        tx_word_t w;
        if (tx_words_due.size() == 0)
        begin
            report_mismatch($sformatf("unexpected word %02h last %0b", data, last));
            return;
        end
        w = tx_words_due.pop_front();
        if (data !== w.data)
            report_mismatch($sformatf("tx_byte %02h, wanted %02h", data, w.data));
        if (last !== w.last)
            report_mismatch($sformatf("tx_last %0b, wanted %0b", last, w.last));
    endtask

    // head, length, command, payload and checksum (frame_body first, then random), tail, extra
    task automatic build_frame(input logic [7:0] head, input logic [7:0] length,
                               input logic [7:0] command, input logic [7:0] tail,
                               input int extra);
        frame_bytes.delete();
        frame_bytes.push_back(head);
        frame_bytes.push_back(length);
        frame_bytes.push_back(command);
        for (int i = 3; i <= int'(length); i++)
        begin
            if (frame_body.size() != 0)
                frame_bytes.push_back(frame_body.pop_front());
            else
                frame_bytes.push_back(8'($urandom_range(255, 0)));
        end
        frame_bytes.push_back(tail);
        for (int i = 0; i < extra; i++)
            frame_bytes.push_back(8'($urandom_range(255, 0)));
        frame_body.delete();
    endtask

    task automatic queue_frame(input bit hold);
        rx_word_t w;
        foreach (frame_bytes[i])
        begin
            w.data = frame_bytes[i];
            w.last = (i == frame_bytes.size() - 1);
            w.hold = hold && (i == 0);
            rx_words.push_back(w);
        end
        queued_words += frame_bytes.size();
        frame_bytes.delete();
    endtask

    task automatic quick_frame(input logic [7:0] command, input logic [7:0] length,
                               input bit hold);
        build_frame(FRAME_HEAD, length, command, FRAME_TAIL, 0);
        queue_frame(hold);
    endtask

    function automatic logic [7:0] pick_command();
        case ($urandom_range(7, 0))
            0: return CMD_ACK_A;
            1: return CMD_ACK_B;
            2: return CMD_ACK_C;
            3: return CMD_GET_DEV;
            4: return CMD_GET_PROD;
            5: return CMD_SET_DEV;
            6: return CMD_SET_PROD;
            default: return 8'($urandom_range(255, 0));
        endcase
    endfunction

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            send_gap      <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                absorb_rx_word(s_axis_tdata, s_axis_tlast);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap != 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    send_gap      <= send_gap - 1;
                end
                else if (rx_words.size() != 0
                         && (!rx_words[0].hold || tx_words_due.size() == 0))
                begin
                    next_word = rx_words.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= next_word.data;
                    s_axis_tlast  <= next_word.last;
                    if ($urandom_range(15, 0) == 0)
                        send_calm = !send_calm;
                    send_gap <= send_calm ? 0 : int'($urandom_range(13, 0));
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            take_stall    <= 0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            check_tx_word(m_axis_tdata, m_axis_tlast);
            if ($urandom_range(15, 0) == 0)
                take_calm = !take_calm;
            stall_draw = take_calm ? 0 : int'($urandom_range(13, 0));
            take_stall    <= stall_draw;
            m_axis_tready <= (stall_draw == 0);
        end
        else if (take_stall != 0)
        begin
            take_stall    <= take_stall - 1;
            m_axis_tready <= (take_stall == 1);
        end
        else
            m_axis_tready <= 1'b1;
    end

    initial
    begin
        #5_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    initial
    begin
        logic [7:0] pick;
        rx_pos     = '0;
        rx_head    = '0;
        rx_length  = '0;
        rx_command = '0;
        rx_tail    = '0;
        foreach (rx_stage[i])
            rx_stage[i] = '0;
        foreach (dev_id[i])
            dev_id[i] = '0;
        foreach (prod_id[i])
            prod_id[i] = '0;

        // ids read back as zero after reset
        quick_frame(CMD_GET_DEV, MIN_LENGTH, 1'b0);
        quick_frame(CMD_GET_PROD, MIN_LENGTH, 1'b0);
        quick_frame(CMD_ACK_A, MIN_LENGTH, 1'b0);
        quick_frame(CMD_ACK_B, 8'd4, 1'b0);
        quick_frame(CMD_ACK_C, MIN_LENGTH, 1'b0);
        repeat (DEVICE_ID_BYTES)
            frame_body.push_back(8'hFF);
        quick_frame(CMD_SET_DEV, 8'(DEVICE_ID_BYTES + 3), 1'b0);
        quick_frame(CMD_GET_DEV, MIN_LENGTH, 1'b1);
        repeat (PRODUCT_ID_BYTES)
            frame_body.push_back(8'hFF);
        quick_frame(CMD_SET_PROD, 8'(PRODUCT_ID_BYTES + 3), 1'b0);
        quick_frame(CMD_GET_PROD, MIN_LENGTH, 1'b0);
        // wrong store lengths, also a payload past the staging depth
        quick_frame(CMD_SET_DEV, 8'(DEVICE_ID_BYTES + 2), 1'b0);
        quick_frame(CMD_SET_PROD, 8'(PRODUCT_ID_BYTES + 4), 1'b0);
        quick_frame(CMD_SET_DEV, 8'd20, 1'b0);
        quick_frame(CMD_GET_DEV, MIN_LENGTH, 1'b0);
        quick_frame(CMD_GET_PROD, MIN_LENGTH, 1'b0);
        // rejected frames
        quick_frame(CMD_ACK_A, 8'd2, 1'b0);
        quick_frame(CMD_ACK_A, 8'd0, 1'b0);
        build_frame(8'hAB, MIN_LENGTH, CMD_ACK_A, FRAME_TAIL, 0);
        queue_frame(1'b0);
        build_frame(FRAME_HEAD, MIN_LENGTH, CMD_ACK_B, 8'h54, 0);
        queue_frame(1'b0);
        build_frame(FRAME_HEAD, 8'd5, CMD_ACK_C, FRAME_TAIL, 0);
        void'(frame_bytes.pop_back());
        queue_frame(1'b0);
        frame_bytes.push_back(FRAME_HEAD);
        queue_frame(1'b0);
        // trailing bytes after the tail, unknown commands
        build_frame(FRAME_HEAD, MIN_LENGTH, CMD_ACK_C, FRAME_TAIL, 3);
        queue_frame(1'b0);
        quick_frame(8'h00, MIN_LENGTH, 1'b0);
        quick_frame(8'hFF, 8'd6, 1'b0);
        quick_frame(CMD_ACK_A, MIN_LENGTH, 1'b1);

        while (queued_words < ITEM_WORDS)
        begin
            case ($urandom_range(9, 0))
                0: quick_frame(CMD_GET_DEV, MIN_LENGTH, 1'b0);
                1: quick_frame(CMD_GET_PROD, MIN_LENGTH, 1'b0);
                2:
                begin
                    pick = 8'($urandom_range(2, 0));
                    build_frame(FRAME_HEAD, 8'(3 + $urandom_range(3, 0)), CMD_ACK_A + pick,
                                FRAME_TAIL, ($urandom_range(3, 0) == 0) ? 2 : 0);
                    queue_frame(1'b0);
                end
                3: quick_frame(CMD_SET_DEV, 8'(DEVICE_ID_BYTES + 3), 1'b0);
                4: quick_frame(CMD_SET_PROD, 8'(PRODUCT_ID_BYTES + 3), 1'b0);
                5: quick_frame(pick_command(), 8'($urandom_range(24, 0)), 1'b0);
                6:
                begin
                    repeat ($urandom_range(6, 1))
                        frame_bytes.push_back(8'($urandom_range(255, 0)));
                    queue_frame(1'b0);
                end
                7:
                begin
                    build_frame(FRAME_HEAD, MIN_LENGTH, pick_command(), FRAME_TAIL, 0);
                    case ($urandom_range(2, 0))
                        0: frame_bytes[0] = frame_bytes[0] ^ (8'h01 << $urandom_range(7, 0));
                        1: frame_bytes[4] = frame_bytes[4] ^ (8'h01 << $urandom_range(7, 0));
                        default: void'(frame_bytes.pop_back());
                    endcase
                    queue_frame(1'b0);
                end
                8:
                begin
                    if ($urandom_range(1, 0) == 0)
                        quick_frame(CMD_SET_DEV, 8'(DEVICE_ID_BYTES + 2 + 2 * $urandom_range(1, 0)),
                                    1'b0);
                    else
                        quick_frame(CMD_SET_PROD,
                                    8'(PRODUCT_ID_BYTES + 2 + 2 * $urandom_range(1, 0)), 1'b0);
                end
                default: quick_frame(($urandom_range(1, 0) == 0) ? CMD_GET_DEV : CMD_GET_PROD,
                                     MIN_LENGTH, 1'b1);
            endcase
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (rx_words.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (tx_words_due.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
